// ----- rtl/nfa_regex_longest_match_core_macros.svh -----
// Assertion macros for the NFA regex longest-match core.
`ifndef NFA_REGEX_LONGEST_MATCH_CORE_MACROS_SVH
`define NFA_REGEX_LONGEST_MATCH_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define NRLM_ASSERT_NOW(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define NRLM_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

// ----- rtl/nrlm_pkg.sv -----
// Shared constants and codes for the NFA regex longest-match core.
package nrlm_pkg;

    localparam int NUM_STATES = 64;
    localparam int MAX_TEXT   = 4096;
    localparam int ST_W       = $clog2(NUM_STATES);
    localparam int TA_W       = $clog2(MAX_TEXT);
    localparam int POS_W      = 13;
    localparam int DEPTH_W    = ST_W + 1;

    localparam logic [7:0] NEWLINE = 8'd10;

    // Input operation codes
    localparam logic [2:0] OP_WR_ENTRY = 3'd0;
    localparam logic [2:0] OP_WR_CLASS = 3'd1;
    localparam logic [2:0] OP_WR_TEXT  = 3'd2;
    localparam logic [2:0] OP_MATCH    = 3'd3;
    localparam logic [2:0] OP_FIND     = 3'd4;

    // NFA entry kinds
    localparam logic [2:0] K_BYTE  = 3'd0;
    localparam logic [2:0] K_CLASS = 3'd1;
    localparam logic [2:0] K_ANY   = 3'd2;
    localparam logic [2:0] K_SPLIT = 3'd3;
    localparam logic [2:0] K_BOL   = 3'd4;
    localparam logic [2:0] K_EOL   = 3'd5;
    localparam logic [2:0] K_MATCH = 3'd6;

    // Configuration register indexes
    localparam logic CFG_START_STATE = 1'b0;
    localparam logic CFG_TEXT_LENGTH = 1'b1;

    typedef struct packed {
        logic [2:0] kind;
        logic [6:0] next_a;
        logic [6:0] next_b;
        logic [7:0] literal;
        logic       negated;
    } entry_t;

endpackage

// ----- rtl/nfa_regex_longest_match_core.sv -----
// NFA regex longest-match core: tables, text buffer and search sequencer.
// Writes (ops 0..2) are accepted only in idle. A search builds the start closure, with an extra
// push step for a split, then per text byte scans each active state, takes its transitions and
// closes over the new states, paced by the single entry-memory port.
// Find-first repeats that per start position; the result waits in a register until taken.
// Reset (aresetn low, synchronous) clears control state; memories are not cleared.
module nfa_regex_longest_match_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op[2:0] state_index[8:3] state_kind[11:9] next_a[18:12] next_b[25:19]
    // literal[33:26] negated[34] class_part[36:35] class_bits[100:37]
    // text_pos[113:101] text_byte[121:114]
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // matched[0] match_start[13:1] match_stop[26:14]
    output logic [31:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [12:0]  cfg_data
);
    localparam int NS = nrlm_pkg::NUM_STATES;
    localparam int SW = nrlm_pkg::ST_W;
    localparam int PW = nrlm_pkg::POS_W;
    localparam int DW = nrlm_pkg::DEPTH_W;

    typedef enum logic [3:0] {
        S_IDLE, S_ANCH_RD, S_ANCH, S_CL_POP, S_CL_ENT, S_CL_ACT, S_CL_PUSHB,
        S_SCAN, S_ADV, S_STEP, S_FIN
    } state_t;

    // Input fields
    logic [2:0]  in_op;
    logic [5:0]  in_idx;
    logic [1:0]  in_part;
    logic [63:0] in_bits;
    logic [12:0] in_pos;
    logic [7:0]  in_tbyte;
    nrlm_pkg::entry_t in_entry;

    assign in_op    = s_tdata[2:0];
    assign in_idx   = s_tdata[8:3];
    assign in_entry = '{kind: s_tdata[11:9], next_a: s_tdata[18:12],
                        next_b: s_tdata[25:19], literal: s_tdata[33:26],
                        negated: s_tdata[34]};
    assign in_part  = s_tdata[36:35];
    assign in_bits  = s_tdata[100:37];
    assign in_pos   = s_tdata[113:101];
    assign in_tbyte = s_tdata[121:114];

    // Memories
    nrlm_pkg::entry_t entry_mem [NS];
    logic [63:0] class_mem [NS*4];
    logic [7:0]  text_mem [nrlm_pkg::MAX_TEXT];
    logic [SW-1:0] stack_mem [NS];

    nrlm_pkg::entry_t ent_q;
    logic [63:0] cls_q;
    logic [7:0]  ta_q, tb_q;
    logic [SW-1:0] stk_q;

    // Registers
    state_t state_reg, state_next;
    logic [SW-1:0] start_state_reg;
    logic [PW-1:0] text_len_reg;
    logic [NS-1:0] active_reg, active_next, acc_reg, acc_next, vis_reg, vis_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [PW-1:0] cpos_reg, cpos_next, mstart_reg, mstart_next, mend_reg, mend_next;
    logic find_reg, find_next, in_step_reg, in_step_next, matched_reg, matched_next;
    logic mflag_reg, mflag_next, ls_reg, ls_next, le_reg, le_next;
    logic [7:0] byte_reg, byte_next;
    logic [6:0] nb_reg, nb_next;
    logic m_valid_reg, m_valid_next;
    logic [31:0] m_data_reg, m_data_next;

    // Push request to the closure stack
    logic push_en;
    logic [6:0] push_st;
    logic do_push;
    logic [SW-1:0] pick;
    logic pick_any;
    logic [SW-1:0] ent_addr;
    logic adv, in_cls;
    logic [PW-1:0] cpos_m1;
    logic [DW-1:0] depth_dec;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign cpos_m1   = cpos_reg - 1'b1;
    assign depth_dec = depth_reg - 1'b1;

    // Lowest pending active state
    always_comb begin
        pick = '0;
        pick_any = 1'b0;
        for (int i = NS - 1; i >= 0; i--) begin
            if (active_reg[i]) begin
                pick = SW'(i);
                pick_any = 1'b1;
            end
        end
    end

    assign ent_addr = (state_reg == S_SCAN) ? pick : stk_q;

    // Transition test of the scanned state on the current byte
    always_comb begin
        in_cls = cls_q[byte_reg[5:0]];
        case (ent_q.kind)
            nrlm_pkg::K_BYTE:  adv = (ent_q.literal == byte_reg);
            nrlm_pkg::K_CLASS: adv = in_cls ^ ent_q.negated;
            nrlm_pkg::K_ANY:   adv = 1'b1;
            default:           adv = 1'b0;
        endcase
    end

    // Memory ports; the popped state is held until the next pop
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            case (in_op)
                nrlm_pkg::OP_WR_ENTRY: entry_mem[in_idx] <= in_entry;
                nrlm_pkg::OP_WR_CLASS: class_mem[{in_idx, in_part}] <= in_bits;
                nrlm_pkg::OP_WR_TEXT: begin
                    if (in_pos < PW'(nrlm_pkg::MAX_TEXT))
                        text_mem[in_pos[nrlm_pkg::TA_W-1:0]] <= in_tbyte;
                end
                default: ;
            endcase
        end
        ent_q <= entry_mem[ent_addr];
        cls_q <= class_mem[{pick, byte_reg[7:6]}];
        ta_q  <= text_mem[cpos_m1[nrlm_pkg::TA_W-1:0]];
        tb_q  <= text_mem[cpos_reg[nrlm_pkg::TA_W-1:0]];
        if (state_reg == S_CL_POP) stk_q <= stack_mem[depth_dec[SW-1:0]];
        if (do_push) stack_mem[depth_reg[SW-1:0]] <= push_st[SW-1:0];
    end

    // Visited test for a push; the visited set is cleared at every closure position, and the start push skips it
    assign do_push = push_en && (push_st < 7'(NS)) &&
                     ((state_reg == S_ANCH) || !vis_reg[push_st[SW-1:0]]);

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        active_next  = active_reg;
        acc_next     = acc_reg;
        vis_next     = vis_reg;
        depth_next   = depth_reg;
        cpos_next    = cpos_reg;
        mstart_next  = mstart_reg;
        mend_next    = mend_reg;
        find_next    = find_reg;
        in_step_next = in_step_reg;
        matched_next = matched_reg;
        mflag_next   = mflag_reg;
        ls_next      = ls_reg;
        le_next      = le_reg;
        byte_next    = byte_reg;
        nb_next      = nb_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        push_en      = 1'b0;
        push_st      = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (in_op == nrlm_pkg::OP_MATCH || in_op == nrlm_pkg::OP_FIND) begin
                        find_next    = (in_op == nrlm_pkg::OP_FIND);
                        mstart_next  = (in_op == nrlm_pkg::OP_FIND) ? '0 : in_pos;
                        cpos_next    = (in_op == nrlm_pkg::OP_FIND) ? '0 : in_pos;
                        matched_next = 1'b0;
                        in_step_next = 1'b0;
                        state_next   = S_ANCH_RD;
                    end
                end
            end
            S_ANCH_RD: state_next = S_ANCH;
            S_ANCH: begin
                // Anchor conditions at the closure position
                ls_next = (cpos_reg == '0) ||
                          ((cpos_m1 < PW'(nrlm_pkg::MAX_TEXT)) && ta_q == nrlm_pkg::NEWLINE);
                le_next = (cpos_reg == text_len_reg) ||
                          ((cpos_reg < text_len_reg) && tb_q == nrlm_pkg::NEWLINE);
                byte_next  = ta_q;
                acc_next   = '0;
                vis_next   = '0;
                mflag_next = 1'b0;
                if (in_step_reg) begin
                    state_next = S_SCAN;
                end else begin
                    active_next = '0;
                    push_en     = 1'b1;
                    push_st     = {1'b0, start_state_reg};
                    state_next  = S_CL_POP;
                end
            end
            S_CL_POP: begin
                if (depth_reg == '0) begin
                    if (mflag_reg) begin
                        matched_next = 1'b1;
                        mend_next    = cpos_reg;
                    end
                    if (in_step_reg) begin
                        state_next = S_SCAN;
                    end else begin
                        active_next = acc_reg;
                        state_next  = S_STEP;
                    end
                end else begin
                    depth_next = depth_reg - 1'b1;
                    state_next = S_CL_ENT;
                end
            end
            S_CL_ENT: state_next = S_CL_ACT;
            S_CL_ACT: begin
                nb_next    = ent_q.next_b;
                state_next = S_CL_POP;
                case (ent_q.kind)
                    nrlm_pkg::K_SPLIT: begin
                        push_en    = 1'b1;
                        push_st    = ent_q.next_a;
                        state_next = S_CL_PUSHB;
                    end
                    nrlm_pkg::K_BOL: begin
                        push_en = ls_reg;
                        push_st = ent_q.next_a;
                    end
                    nrlm_pkg::K_EOL: begin
                        push_en = le_reg;
                        push_st = ent_q.next_a;
                    end
                    default: begin
                        acc_next[stk_q] = 1'b1;
                        if (ent_q.kind == nrlm_pkg::K_MATCH) mflag_next = 1'b1;
                    end
                endcase
            end
            S_CL_PUSHB: begin
                push_en    = 1'b1;
                push_st    = nb_reg;
                state_next = S_CL_POP;
            end
            S_SCAN: begin
                if (pick_any) begin
                    active_next[pick] = 1'b0;
                    state_next = S_ADV;
                end else begin
                    active_next = acc_reg;
                    state_next  = S_STEP;
                end
            end
            S_ADV: begin
                push_en    = adv;
                push_st    = ent_q.next_a;
                state_next = adv ? S_CL_POP : S_SCAN;
            end
            S_STEP: begin
                if ((cpos_reg < text_len_reg) && (active_reg != '0)) begin
                    cpos_next    = cpos_reg + 1'b1;
                    in_step_next = 1'b1;
                    state_next   = S_ANCH_RD;
                end else if (find_reg && !matched_reg && (mstart_reg < text_len_reg)) begin
                    mstart_next  = mstart_reg + 1'b1;
                    cpos_next    = mstart_reg + 1'b1;
                    in_step_next = 1'b0;
                    state_next   = S_ANCH_RD;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'd0, matched_reg ? mend_reg : 13'd0,
                                    matched_reg ? mstart_reg : 13'd0, matched_reg};
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (do_push) begin
            vis_next[push_st[SW-1:0]] = 1'b1;
            depth_next = depth_reg + 1'b1;
        end
        if (state_reg == S_ANCH && !in_step_reg) begin
            depth_next = DW'(1);
        end
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            start_state_reg <= '0;
            text_len_reg    <= '0;
            active_reg      <= '0;
            acc_reg         <= '0;
            vis_reg         <= '0;
            depth_reg       <= '0;
            find_reg        <= 1'b0;
            in_step_reg     <= 1'b0;
            matched_reg     <= 1'b0;
            mflag_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            acc_reg     <= acc_next;
            vis_reg     <= vis_next;
            depth_reg   <= depth_next;
            find_reg    <= find_next;
            in_step_reg <= in_step_next;
            matched_reg <= matched_next;
            mflag_reg   <= mflag_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    nrlm_pkg::CFG_START_STATE: start_state_reg <= cfg_data[SW-1:0];
                    nrlm_pkg::CFG_TEXT_LENGTH:
                        text_len_reg <= (cfg_data > PW'(nrlm_pkg::MAX_TEXT)) ?
                                        PW'(nrlm_pkg::MAX_TEXT) : cfg_data;
                    default: ;
                endcase
            end
        end
        cpos_reg   <= cpos_next;
        mstart_reg <= mstart_next;
        mend_reg   <= mend_next;
        ls_reg     <= ls_next;
        le_reg     <= le_next;
        byte_reg   <= byte_next;
        nb_reg     <= nb_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ----- rtl/nrlm_checker.sv -----
// Port-level checker for the NFA regex longest-match core, with its bind.
`include "nfa_regex_longest_match_core_macros.svh"

module nrlm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    // A held result stays offered and unchanged
    `NRLM_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `NRLM_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    // No match reports zero bounds
    `NRLM_ASSERT_NOW(a_nomatch_zero, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[26:1] == 26'd0)
    // A match never ends before it starts
    `NRLM_ASSERT_NOW(a_order, aclk, aresetn, m_tvalid && m_tdata[0], m_tdata[26:14] >= m_tdata[13:1])
endmodule

bind nfa_regex_longest_match_core nrlm_checker u_nrlm_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata)
);

// ----- tb/tb_nfa_regex_longest_match_core.sv -----
// Self-checking testbench for the NFA regex longest-match core.
`timescale 1ns / 100ps

module tb_nfa_regex_longest_match_core;

    localparam int    WATCHDOG_LIMIT = 400000;
    localparam int    RANDOM_ITEMS   = 1950;
    localparam int    TEXT_FILLED    = 40;   // text bytes 0..39 always written
    localparam int    MAX_LEN        = 32;
    localparam logic [2:0] K_DEAD    = 3'd7;
    localparam logic [6:0] NXT_NONE  = 7'd64;

    typedef struct {
        logic [2:0]  op;
        logic [5:0]  idx;
        logic [2:0]  kind;
        logic [6:0]  next_a;
        logic [6:0]  next_b;
        logic [7:0]  literal;
        logic        negated;
        logic [1:0]  part;
        logic [63:0] bits;
        logic [12:0] pos;
        logic [7:0]  tbyte;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [12:0] mstart;
        logic [12:0] mend;
    } match_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_index;
    logic [12:0]  cfg_data;

    nfa_regex_longest_match_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    // Shadow copy of the engine's tables and registers
    logic [2:0]  ent_kind [nrlm_pkg::NUM_STATES];
    logic [6:0]  ent_na   [nrlm_pkg::NUM_STATES];
    logic [6:0]  ent_nb   [nrlm_pkg::NUM_STATES];
    logic [7:0]  ent_lit  [nrlm_pkg::NUM_STATES];
    logic        ent_neg  [nrlm_pkg::NUM_STATES];
    logic [63:0] cls_mem  [nrlm_pkg::NUM_STATES*4];
    logic [7:0]  text_mem [nrlm_pkg::MAX_TEXT];
    logic [63:0] seen_q;
    int          start_sh;
    int          len_sh;

    match_t match_q[$];
    int     errors;
    int     n_items;
    int     n_results;
    int     n_hits;
    int     n_searches;
    bit     quiet;
    int     rdy_hold;
    int     rr;
    int     idle_cnt;

    // Anchor tests against the shadow text
    function automatic bit at_bol(int pos);
        if (pos == 0) return 1'b1;
        return (pos - 1) < nrlm_pkg::MAX_TEXT && text_mem[pos-1] == nrlm_pkg::NEWLINE;
    endfunction

    function automatic bit at_eol(int pos);
        if (pos == len_sh) return 1'b1;
        return pos < len_sh && text_mem[pos] == nrlm_pkg::NEWLINE;
    endfunction

    // Epsilon closure of s0 at pos, folded into set; seen_q is shared per step
    function automatic void eps_close(inout logic [63:0] set, input logic [6:0] s0,
                                      input int pos);
        logic [6:0] stk[$];
        logic [6:0] cand[2];
        logic [6:0] st;
        int nc;
        cand[0] = s0;
        nc = 1;
        while (1) begin
            for (int k = 0; k < nc; k++)
                if (cand[k] < nrlm_pkg::NUM_STATES && !seen_q[cand[k][5:0]]) begin
                    seen_q[cand[k][5:0]] = 1'b1;
                    stk.push_back(cand[k]);
                end
            if (stk.size() == 0) break;
            st = stk.pop_back();
            nc = 0;
            case (ent_kind[st[5:0]])
                nrlm_pkg::K_SPLIT: begin
                    cand[0] = ent_na[st[5:0]];
                    cand[1] = ent_nb[st[5:0]];
                    nc = 2;
                end
                nrlm_pkg::K_BOL: if (at_bol(pos)) begin
                    cand[0] = ent_na[st[5:0]];
                    nc = 1;
                end
                nrlm_pkg::K_EOL: if (at_eol(pos)) begin
                    cand[0] = ent_na[st[5:0]];
                    nc = 1;
                end
                default: set[st[5:0]] = 1'b1;
            endcase
        end
    endfunction

    function automatic bit has_accept(logic [63:0] set);
        for (int i = 0; i < nrlm_pkg::NUM_STATES; i++)
            if (set[i] && ent_kind[i] == nrlm_pkg::K_MATCH) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit consumes(int st, logic [7:0] b);
        case (ent_kind[st])
            nrlm_pkg::K_BYTE:  return ent_lit[st] == b;
            nrlm_pkg::K_CLASS: return cls_mem[st*4 + b[7:6]][b[5:0]] ^ ent_neg[st];
            nrlm_pkg::K_ANY:   return 1'b1;
            default:           return 1'b0;
        endcase
    endfunction

    // Longest match anchored at start; fin gets the end position
    function automatic bit longest_from(int start, output int fin);
        logic [63:0] act;
        logic [63:0] nxt;
        bit hit;
        hit = 1'b0;
        fin = 0;
        seen_q = '0;
        act = '0;
        eps_close(act, 7'(start_sh), start);
        if (has_accept(act)) begin
            hit = 1'b1;
            fin = start;
        end
        for (int pos = start; pos < len_sh && act != 0; pos++) begin
            nxt = '0;
            seen_q = '0;
            for (int st = 0; st < nrlm_pkg::NUM_STATES; st++)
                if (act[st] && consumes(st, text_mem[pos]))
                    eps_close(nxt, ent_na[st], pos + 1);
            act = nxt;
            if (has_accept(act)) begin
                hit = 1'b1;
                fin = pos + 1;
            end
        end
        return hit;
    endfunction

    // Apply one accepted request to the shadow state, queue any search result
    function automatic void predict_request(req_t r);
        match_t m;
        int fin;
        m = '0;
        case (r.op)
            nrlm_pkg::OP_WR_ENTRY: begin
                ent_kind[r.idx] = r.kind;
                ent_na[r.idx]   = r.next_a;
                ent_nb[r.idx]   = r.next_b;
                ent_lit[r.idx]  = r.literal;
                ent_neg[r.idx]  = r.negated;
            end
            nrlm_pkg::OP_WR_CLASS: cls_mem[r.idx*4 + r.part] = r.bits;
            nrlm_pkg::OP_WR_TEXT:
                if (r.pos < nrlm_pkg::MAX_TEXT) text_mem[r.pos] = r.tbyte;
            nrlm_pkg::OP_MATCH: begin
                if (longest_from(r.pos, fin)) begin
                    m.hit = 1'b1;
                    m.mstart = r.pos;
                    m.mend = 13'(fin);
                end
                match_q.push_back(m);
            end
            nrlm_pkg::OP_FIND: begin
                for (int p = 0; p <= len_sh; p++)
                    if (longest_from(p, fin)) begin
                        m.hit = 1'b1;
                        m.mstart = 13'(p);
                        m.mend = 13'(fin);
                        break;
                    end
                match_q.push_back(m);
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Send one request; tvalid stays high when the next one follows at once
    task automatic send_req(req_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, r.tbyte, r.pos, r.bits, r.part, r.negated, r.literal,
                     r.next_b, r.next_a, r.kind, r.idx, r.op};
        do @(posedge aclk); while (!s_tready);
        predict_request(r);
        n_items++;
        if (r.op == nrlm_pkg::OP_MATCH || r.op == nrlm_pkg::OP_FIND) n_searches++;
    endtask

    function automatic req_t blank_req(logic [2:0] op);
        req_t r;
        r = '{op: op, idx: '0, kind: '0, next_a: '0, next_b: '0, literal: '0,
              negated: '0, part: '0, bits: '0, pos: '0, tbyte: '0};
        return r;
    endfunction

    task automatic put_entry(int idx, logic [2:0] kind, logic [6:0] na, logic [6:0] nb,
                             logic [7:0] lit, logic neg);
        req_t r;
        r = blank_req(nrlm_pkg::OP_WR_ENTRY);
        r.idx = 6'(idx);
        r.kind = kind;
        r.next_a = na;
        r.next_b = nb;
        r.literal = lit;
        r.negated = neg;
        r.bits = {$urandom, $urandom};
        send_req(r);
    endtask

    task automatic put_class(int idx, int part, logic [63:0] bits);
        req_t r;
        r = blank_req(nrlm_pkg::OP_WR_CLASS);
        r.idx = 6'(idx);
        r.part = 2'(part);
        r.bits = bits;
        send_req(r);
    endtask

    task automatic put_text(int pos, logic [7:0] b);
        req_t r;
        r = blank_req(nrlm_pkg::OP_WR_TEXT);
        r.pos = 13'(pos);
        r.tbyte = b;
        send_req(r);
    endtask

    task automatic search(logic [2:0] op, int pos);
        req_t r;
        r = blank_req(op);
        r.pos = 13'(pos);
        r.idx = 6'($urandom);
        send_req(r);
    endtask

    // Stop sending and let every pending result and write retire
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (match_q.size() != 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 13'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == nrlm_pkg::CFG_START_STATE) start_sh = value & 63;
        else len_sh = (value & 13'h1fff) > nrlm_pkg::MAX_TEXT ?
                      nrlm_pkg::MAX_TEXT : (value & 13'h1fff);
    endtask

    function automatic logic [7:0] text_char();
        int r;
        r = $urandom_range(9);
        if (r < 4) return "a";
        if (r < 7) return "b";
        if (r < 9) return nrlm_pkg::NEWLINE;
        return 8'($urandom);
    endfunction

    function automatic logic [6:0] pick_next(int n);
        int r;
        r = $urandom_range(19);
        if (r == 0) return NXT_NONE;
        if (r == 1) return 7'($urandom_range(64, 127));
        return 7'($urandom_range(0, n - 1));
    endfunction

    // All entries dead, text prefix filled, so no search reads an unwritten cell
    task automatic test_setup();
        for (int i = 0; i < nrlm_pkg::NUM_STATES; i++)
            put_entry(i, K_DEAD, NXT_NONE, 7'd127, 8'd0, 1'b0);
        for (int i = 0; i < TEXT_FILLED; i++) put_text(i, text_char());
        wait_idle();
    endtask

    // Small hand-built program touching every kind and both anchors
    task automatic test_directed();
        put_text(0, "a");
        put_text(1, "b");
        put_text(2, nrlm_pkg::NEWLINE);
        put_text(3, "a");
        put_entry(0, nrlm_pkg::K_SPLIT, 7'd1, 7'd4, 8'd0, 1'b0);
        put_entry(1, nrlm_pkg::K_BYTE, 7'd2, 7'd127, "a", 1'b0);
        put_entry(2, nrlm_pkg::K_CLASS, 7'd3, NXT_NONE, 8'hff, 1'b1);
        put_class(2, 0, 64'h1 << nrlm_pkg::NEWLINE);
        put_class(2, 1, '0);
        put_class(2, 2, '0);
        put_class(2, 3, '1);
        put_entry(3, nrlm_pkg::K_ANY, 7'd5, NXT_NONE, 8'd0, 1'b0);
        put_entry(4, nrlm_pkg::K_BOL, 7'd1, NXT_NONE, 8'd0, 1'b0);
        put_entry(5, nrlm_pkg::K_EOL, 7'd6, NXT_NONE, 8'd0, 1'b0);
        put_entry(6, nrlm_pkg::K_MATCH, NXT_NONE, NXT_NONE, 8'd0, 1'b0);
        wait_idle();
        write_reg(nrlm_pkg::CFG_START_STATE, 0);
        write_reg(nrlm_pkg::CFG_TEXT_LENGTH, 4);
        for (int p = 0; p <= 5; p++) search(nrlm_pkg::OP_MATCH, p);
        search(nrlm_pkg::OP_MATCH, 8191);
        search(nrlm_pkg::OP_FIND, 0);
        wait_idle();
        // empty text, then a start state that matches empty
        write_reg(nrlm_pkg::CFG_TEXT_LENGTH, 0);
        search(nrlm_pkg::OP_MATCH, 0);
        search(nrlm_pkg::OP_FIND, 0);
        wait_idle();
        write_reg(nrlm_pkg::CFG_START_STATE, 6);
        search(nrlm_pkg::OP_MATCH, 3);
        search(nrlm_pkg::OP_FIND, 0);
        wait_idle();
    endtask

    // Top start state and full-size text at the buffer's far end
    task automatic test_extremes();
        put_entry(63, nrlm_pkg::K_MATCH, 7'd127, NXT_NONE, 8'hff, 1'b1);
        put_text(4093, nrlm_pkg::NEWLINE);
        put_text(4094, "a");
        put_text(4095, nrlm_pkg::NEWLINE);
        wait_idle();
        write_reg(nrlm_pkg::CFG_START_STATE, 63);
        write_reg(nrlm_pkg::CFG_TEXT_LENGTH, 8191);   // saturates to the buffer size
        search(nrlm_pkg::OP_MATCH, 4094);
        search(nrlm_pkg::OP_MATCH, 4095);
        search(nrlm_pkg::OP_MATCH, 4096);
        search(nrlm_pkg::OP_MATCH, 8191);
        search(nrlm_pkg::OP_FIND, 0);
        wait_idle();
        write_reg(nrlm_pkg::CFG_TEXT_LENGTH, nrlm_pkg::MAX_TEXT);
        search(nrlm_pkg::OP_MATCH, 4096);
        wait_idle();
    endtask

    // Random small programs over a short text, searched several ways
    task automatic test_random_programs();
        req_t r;
        int n;
        int len;
        int scen;
        logic [2:0] kind;
        int w;
        scen = 0;
        while (n_items < RANDOM_ITEMS) begin
            quiet = (scen % 5 == 4);
            n = $urandom_range(2, 12);
            for (int i = 0; i < n; i++) begin
                w = $urandom_range(99);
                kind = w < 28 ? nrlm_pkg::K_BYTE : w < 43 ? nrlm_pkg::K_CLASS :
                       w < 53 ? nrlm_pkg::K_ANY : w < 73 ? nrlm_pkg::K_SPLIT :
                       w < 80 ? nrlm_pkg::K_BOL : w < 87 ? nrlm_pkg::K_EOL :
                       w < 97 ? nrlm_pkg::K_MATCH : K_DEAD;
                put_entry(i, kind, pick_next(n), pick_next(n), text_char(), 1'($urandom));
                if (kind == nrlm_pkg::K_CLASS)
                    for (int q = 0; q < 4; q++) put_class(i, q, {$urandom, $urandom});
            end
            repeat ($urandom_range(0, 5)) put_text($urandom_range(0, TEXT_FILLED - 1), text_char());
            wait_idle();
            write_reg(nrlm_pkg::CFG_START_STATE, $urandom_range(0, n - 1));
            w = $urandom_range(9);
            len = w == 0 ? 0 : w == 1 ? MAX_LEN : $urandom_range(1, 16);
            write_reg(nrlm_pkg::CFG_TEXT_LENGTH, len);
            repeat ($urandom_range(5, 12)) begin
                w = $urandom_range(99);
                if (w < 65) search(nrlm_pkg::OP_MATCH, $urandom_range(0, len + 4));
                else if (w < 72) search(nrlm_pkg::OP_MATCH, $urandom_range(4097, 8191));
                else if (w < 80) search(nrlm_pkg::OP_FIND, 0);
                else if (w < 88) begin
                    // stray writes off the active program, full field range
                    r = blank_req(nrlm_pkg::OP_WR_ENTRY);
                    r.idx = 6'($urandom_range(n, 63));
                    r.kind = 3'($urandom);
                    r.next_a = 7'($urandom);
                    r.next_b = 7'($urandom);
                    r.literal = 8'($urandom);
                    r.negated = 1'($urandom);
                    r.part = 2'($urandom);
                    r.bits = {$urandom, $urandom};
                    r.pos = 13'($urandom);
                    r.tbyte = 8'($urandom);
                    if ($urandom_range(1)) r.op = nrlm_pkg::OP_WR_CLASS;
                    send_req(r);
                end else if (w < 94) begin
                    r = blank_req(nrlm_pkg::OP_WR_TEXT);
                    r.pos = 13'($urandom_range(TEXT_FILLED, 8191));
                    r.tbyte = 8'($urandom);
                    send_req(r);
                end else begin
                    // unused op codes are ignored
                    r = blank_req(3'($urandom_range(5, 7)));
                    r.pos = 13'($urandom);
                    r.bits = {$urandom, $urandom};
                    r.idx = 6'($urandom);
                    send_req(r);
                end
            end
            wait_idle();
            scen++;
        end
        quiet = 1'b0;
    endtask

    // Result receiver with random backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b1;
            rdy_hold <= 0;
        end else if (quiet) begin
            m_tready <= 1'b1;
        end else if (rdy_hold > 0) begin
            rdy_hold <= rdy_hold - 1;
        end else begin
            rr = $urandom_range(99);
            if (rr < 60) begin
                m_tready <= 1'b1;
                rdy_hold <= $urandom_range(0, 6);
            end else begin
                m_tready <= 1'b0;
                rdy_hold <= rr < 92 ? $urandom_range(0, 3) : $urandom_range(10, 50);
            end
        end
    end

    // Compare each result with the oldest queued search
    always @(posedge aclk) begin
        match_t exp_m;
        if (aresetn && m_tvalid && m_tready) begin
            if (match_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", m_tdata[26:0]);
            end else begin
                exp_m = match_q.pop_front();
                n_results++;
                if (exp_m.hit) n_hits++;
                if (m_tdata[0] !== exp_m.hit || m_tdata[13:1] !== exp_m.mstart ||
                    m_tdata[26:14] !== exp_m.mend) begin
                    errors++;
                    if (errors <= 10)
                        $display("result mismatch: exp hit=%0b start=%0d end=%0d, got hit=%0b start=%0d end=%0d",
                                 exp_m.hit, exp_m.mstart, exp_m.mend,
                                 m_tdata[0], m_tdata[13:1], m_tdata[26:14]);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cnt);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = nrlm_pkg::CFG_START_STATE;
        cfg_data  = '0;
        errors    = 0;
        n_items   = 0;
        n_results = 0;
        n_hits    = 0;
        n_searches = 0;
        quiet     = 1'b0;
        seen_q    = '0;
        start_sh  = 0;
        len_sh    = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_setup();
        test_directed();
        test_extremes();
        test_random_programs();

        wait_idle();
        repeat (50) @(posedge aclk);
        if (match_q.size() != 0) errors++;
        $display("Sent %0d requests, %0d of them searches; %0d results checked, %0d matched.",
                 n_items, n_searches, n_results, n_hits);
        $display("Covered all entry kinds, anchors, empty and saturated text, %0d mismatches.",
                 errors);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
